@@ hdl/stream_find_replace_assert.svh @@
// Assertion macros for the streaming find-and-replace block.
// Included by the top level; depends on nothing else.
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SFR_ASSERT_SAME(label, clk, rst_n, pre, con) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (con)) \
    else $error("stream_find_replace: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define SFR_ASSERT_NEXT(label, clk, rst_n, pre, con) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (con)) \
    else $error("stream_find_replace: next-cycle check failed");

`endif

@@ hdl/sfr_pkg.sv @@
// Shared types and constants of the streaming find-and-replace block.
// Used by the front, queue, back and top level; depends on nothing.
package sfr_pkg;

  // Byte lanes of one job: pattern and replacement never exceed 16 bytes.
  localparam int unsigned LANES = 16;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QLVL_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LO = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAT_HI = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LEN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_REP_LO = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_REP_HI = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_REP_LEN = 3'd5;

  typedef struct packed {
    logic [2*CFG_DATA_W-1:0] pattern;
    logic [LEN_W-1:0]        pat_len;
    logic [2*CFG_DATA_W-1:0] repl;
    logic [LEN_W-1:0]        rep_len;
  } cfg_t;

  // One classified item: bytes to emit in order, how many, and end mark.
  typedef struct packed {
    logic [LANES-1:0][7:0] data;
    logic [LEN_W-1:0]      count;
    logic                  last;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QLVL_W-1:0] level;
  } queue_stat_t;

endpackage

@@ hdl/sfr_front.sv @@
// Front end: holds the match window, compares it and classifies each item into a job.
// Depends on sfr_pkg.
module sfr_front import sfr_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned REPLACEMENT_MAX = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  cfg_t                                    cfg_i,
  input  logic                                    win_clear_i,
  input  logic                                    accept_i,
  input  logic [7:0]                              text_byte_i,
  input  logic                                    end_of_text_i,
  output logic                                    job_valid_o,
  output job_t                                    job_o,
  output logic [$clog2(((PATTERN_MAX < 16) ? PATTERN_MAX : 16) + 1)-1:0] win_count_o
);

  localparam int unsigned WIN_CAP = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
  localparam int unsigned REP_CAP = (REPLACEMENT_MAX < 16) ? REPLACEMENT_MAX : 16;
  localparam int unsigned CNT_W = $clog2(WIN_CAP + 1);

  logic [WIN_CAP-1:0][7:0] win_q, win_d, w, sh;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [LEN_W-1:0]        plen, rlen, cnt_eff, cnt_next;
  logic                    full_win, match;

  always_comb begin
    plen = (cfg_i.pat_len > LEN_W'(WIN_CAP)) ? LEN_W'(WIN_CAP) : cfg_i.pat_len;
    rlen = (cfg_i.rep_len > LEN_W'(REP_CAP)) ? LEN_W'(REP_CAP) : cfg_i.rep_len;
    cnt_eff = (LEN_W'(cnt_q) >= plen) ? '0 : LEN_W'(cnt_q);
    cnt_next = cnt_eff + LEN_W'(1);
    full_win = (cnt_next == plen);
    // insert the new byte at the fill position
    for (int i = 0; i < WIN_CAP; i++) begin
      w[i] = (LEN_W'(i) == cnt_eff) ? text_byte_i : win_q[i];
    end
    match = 1'b1;
    for (int i = 0; i < WIN_CAP; i++) begin
      if (LEN_W'(i) < plen && w[i] != cfg_i.pattern[8*i +: 8]) begin
        match = 1'b0;
      end
    end
    for (int i = 0; i < WIN_CAP - 1; i++) begin
      sh[i] = w[i+1];
    end
    sh[WIN_CAP-1] = w[WIN_CAP-1];
  end

  always_comb begin
    job_valid_o = 1'b0;
    job_o.data = '0;
    job_o.count = '0;
    job_o.last = end_of_text_i;
    win_d = win_q;
    cnt_d = cnt_q;
    if (plen == '0) begin
      job_valid_o = 1'b1;
      job_o.data[0] = text_byte_i;
      job_o.count = LEN_W'(1);
    end else if (full_win && match) begin
      for (int i = 0; i < REP_CAP; i++) begin
        job_o.data[i] = cfg_i.repl[8*i +: 8];
      end
      job_o.count = rlen;
      job_valid_o = (rlen != '0) || end_of_text_i;
      cnt_d = '0;
    end else if (full_win) begin
      // mismatch: emit the oldest byte; on the last byte flush the rest too
      for (int i = 0; i < WIN_CAP; i++) begin
        job_o.data[i] = w[i];
      end
      job_valid_o = 1'b1;
      if (end_of_text_i) begin
        job_o.count = plen;
        cnt_d = '0;
      end else begin
        job_o.count = LEN_W'(1);
        win_d = sh;
        cnt_d = CNT_W'(plen - LEN_W'(1));
      end
    end else begin
      win_d = w;
      if (end_of_text_i) begin
        for (int i = 0; i < WIN_CAP; i++) begin
          job_o.data[i] = w[i];
        end
        job_o.count = cnt_next;
        job_valid_o = 1'b1;
        cnt_d = '0;
      end else begin
        cnt_d = CNT_W'(cnt_next);
      end
    end
    if (!accept_i) begin
      job_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (win_clear_i) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

  assign win_count_o = cnt_q;

endmodule

@@ hdl/sfr_queue.sv @@
// Short job queue between front and back.
// Depends on sfr_pkg.
module sfr_queue import sfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        push_job_i,
  input  logic        pop_i,
  output job_t        head_o,
  output queue_stat_t stat_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QLVL_W-1:0] lvl_q;
  logic              do_push, do_pop;

  assign stat_o.full = (lvl_q == QLVL_W'(QUEUE_DEPTH));
  assign stat_o.empty = (lvl_q == '0);
  assign stat_o.level = lvl_q;
  assign do_push = push_i && !stat_o.full;
  assign do_pop = pop_i && !stat_o.empty;
  assign head_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      lvl_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        lvl_q <= lvl_q + QLVL_W'(1);
      end else if (do_pop && !do_push) begin
        lvl_q <= lvl_q - QLVL_W'(1);
      end
    end
  end

endmodule

@@ hdl/sfr_back.sv @@
// Back end: expands queued jobs into result bytes, one per cycle while the output register is empty or popped.
// Depends on sfr_pkg.
module sfr_back import sfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       out_last_o
);

  logic [LEN_W-1:0] idx_q, idx_d;
  logic             valid_q, advance, final_byte;
  logic [7:0]       byte_q;
  logic             present_q, last_q;

  assign advance = !valid_q || pop_i;
  assign final_byte = (job_i.count == '0) || (idx_q == job_i.count - LEN_W'(1));
  assign job_pop_o = job_valid_i && advance && final_byte;
  assign idx_d = final_byte ? '0 : idx_q + LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q <= '0;
    end else if (advance) begin
      valid_q <= job_valid_i;
      if (job_valid_i) begin
        idx_q <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && job_valid_i) begin
      if (job_i.count == '0) begin
        byte_q <= 8'h00;
        present_q <= 1'b0;
      end else begin
        byte_q <= job_i.data[idx_q[$clog2(LANES)-1:0]];
        present_q <= 1'b1;
      end
      last_q <= job_i.last && final_byte;
    end
  end

  assign empty_o = !valid_q;
  assign out_byte_o = byte_q;
  assign byte_present_o = present_q;
  assign out_last_o = last_q;

endmodule

@@ hdl/stream_find_replace.sv @@
// Top level of the streaming find-and-replace block: configuration registers,
// front end, job queue and back end. Depends on sfr_pkg and the assertion header.
//
//   channel   direction  handshake           payload
//   text in   input      push_i / full_o     text_byte_i, end_of_text_i
//   results   output     pop_i / empty_o     out_byte_o, byte_present_o, out_last_o
//   config    input      cfg_we_i            cfg_addr_i, cfg_wdata_i
//
// One text byte is accepted per cycle while the four-entry job queue has room.
// A result byte leaves per cycle while pop_i is high; a match with an n-byte
// replacement, or a flush at end of text, becomes n result bytes in the back
// end while the queue fills, and input stalls only once four jobs wait.
// The job of an item is written into the queue at its accepting edge and is
// then loaded into the output register that drives the result ports.
// Reset clears the window fill, the queue and the output valid flag; a write of
// pattern_length also drops the bytes held in the window.
`include "stream_find_replace_assert.svh"
module stream_find_replace import sfr_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned REPLACEMENT_MAX = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_text_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [7:0]            out_byte_o,
  output logic                  byte_present_o,
  output logic                  out_last_o
);

  localparam int unsigned WIN_CAP = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
  localparam int unsigned CNT_W = $clog2(WIN_CAP + 1);

  cfg_t             cfg_q;
  logic             accept, pat_len_wr;
  logic             job_valid, job_pop;
  job_t             job, head;
  queue_stat_t      qstat;
  logic [CNT_W-1:0] win_count;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  assign pat_len_wr = cfg_we_i && (cfg_addr_i == CFG_PAT_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_PAT_LO:  cfg_q.pattern[CFG_DATA_W-1:0] <= cfg_wdata_i;
        CFG_PAT_HI:  cfg_q.pattern[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_wdata_i;
        CFG_PAT_LEN: cfg_q.pat_len <= cfg_wdata_i[LEN_W-1:0];
        CFG_REP_LO:  cfg_q.repl[CFG_DATA_W-1:0] <= cfg_wdata_i;
        CFG_REP_HI:  cfg_q.repl[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_wdata_i;
        CFG_REP_LEN: cfg_q.rep_len <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold input whenever the queue cannot take another job.
  assign full_o = qstat.full;
  assign accept = push_i && !full_o;

  sfr_front #(
    .PATTERN_MAX    (PATTERN_MAX),
    .REPLACEMENT_MAX(REPLACEMENT_MAX)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .win_clear_i  (pat_len_wr),
    .accept_i     (accept),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .job_valid_o  (job_valid),
    .job_o        (job),
    .win_count_o  (win_count)
  );

  sfr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (job_valid),
    .push_job_i(job),
    .pop_i     (job_pop),
    .head_o    (head),
    .stat_o    (qstat)
  );

  sfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!qstat.empty),
    .job_i         (head),
    .job_pop_o     (job_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .out_byte_o    (out_byte_o),
    .byte_present_o(byte_present_o),
    .out_last_o    (out_last_o)
  );

  // An empty end marker is always the final result and carries a zero byte.
  `SFR_ASSERT_SAME(a_marker_last, clk_i, rst_ni, !empty_o && !byte_present_o, out_last_o && out_byte_o == 8'h00)
  // The queue never holds more jobs than it has entries.
  `SFR_ASSERT_SAME(a_queue_level, clk_i, rst_ni, 1'b1, qstat.level <= QLVL_W'(QUEUE_DEPTH))
  // The end of a text, or a new pattern length, leaves the window empty.
  `SFR_ASSERT_NEXT(a_window_flushed, clk_i, rst_ni, (accept && end_of_text_i) || pat_len_wr, win_count == '0)

endmodule
